### rtl/core/ebse_pkg.sv
// ----------------------------------------------------------------------------
// ebse_pkg
// Shared widths, constants, controller states and the command/status structs
// of the erased block skip encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ebse_pkg;

	localparam int ADDR_W             = 24;
	localparam int BYTE_W             = 8;
	localparam int SKIP_W             = 10;
	localparam int BLOCK_BYTES_DEF    = 32;
	localparam int MAX_RUN_BLOCKS_DEF = 16;

	localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

	localparam logic KIND_LITERAL = 1'b0;
	localparam logic KIND_SKIP    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SKIP,
		ST_FFLIT,
		ST_LIT_RD,
		ST_LIT
	} state_t;

	typedef enum logic [1:0] {
		SEL_SKIP,
		SEL_FF,
		SEL_LIT
	} out_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic     accept;    // take the offered byte
		logic     out_load;  // load the result register
		out_sel_t out_sel;
		logic     out_last;  // final result of this transaction
		logic     idx_inc;
		logic     idx_clr;
		logic     rd_en;     // read the block buffer
		logic     rd_ahead;  // read at idx + 1 instead of idx
		logic     finish;    // all results of the transaction are out
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic block_end;    // offered byte closes a block
		logic has_skip;     // a skip result follows it
		logic has_ff;       // a block of literal 0xFF follows it
		logic has_lit;      // the buffered block follows as literals
		logic lit_pending;  // latched has_lit of the accepted byte
		logic out_free;     // result register can take a new result
		logic idx_ff_end;
		logic idx_lit_end;
	} dp_status_t;

endpackage

`default_nettype wire

### rtl/core/ebse_if.sv
// ----------------------------------------------------------------------------
// ebse_if
// Valid/ready channels of the encoder: image bytes in, encoded results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ebse_in_if;
	import ebse_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              last_byte;

	modport source (output valid, output in_byte, output last_byte, input ready);
	modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface ebse_out_if;
	import ebse_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [BYTE_W-1:0] out_byte;
	logic [SKIP_W-1:0] skip_bytes;
	logic [ADDR_W-1:0] address;
	logic              last_of_run;

	modport source (output valid, output kind, output out_byte, output skip_bytes,
		output address, output last_of_run, input ready);
	modport sink   (input valid, input kind, input out_byte, input skip_bytes,
		input address, input last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/core/ebse_ram.sv
// ----------------------------------------------------------------------------
// ebse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ebse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data until the next read
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/ebse_ctrl.sv
// ----------------------------------------------------------------------------
// ebse_ctrl
// Sequencer: takes one byte, then walks the skip, erased-literal and literal
// phases that the byte releases before it takes the next byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ebse_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire ebse_pkg::dp_status_t  status,
	output ebse_pkg::ctl_cmd_t         cmd
);
	import ebse_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.out_sel = SEL_SKIP;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (status.block_end) begin
						if (status.has_skip) begin
							state_d = ST_SKIP;
						end else if (status.has_ff) begin
							state_d = ST_FFLIT;
						end else if (status.has_lit) begin
							state_d = ST_LIT_RD;
						end
					end
				end
			end
			ST_SKIP: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_SKIP;
					cmd.out_last = !status.lit_pending;
					if (status.lit_pending) begin
						state_d = ST_LIT_RD;
					end else begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end
				end
			end
			ST_FFLIT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_FF;
					if (status.idx_ff_end) begin
						cmd.out_last = !status.lit_pending;
						cmd.idx_clr  = 1'b1;
						if (status.lit_pending) begin
							state_d = ST_LIT_RD;
						end else begin
							cmd.finish = 1'b1;
							state_d    = ST_IDLE;
						end
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			ST_LIT_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_LIT;
			end
			ST_LIT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_LIT;
					if (status.idx_lit_end) begin
						cmd.out_last = 1'b1;
						cmd.finish   = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						// fetch the next byte while this one goes out
						cmd.idx_inc  = 1'b1;
						cmd.rd_en    = 1'b1;
						cmd.rd_ahead = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/ebse_dp.sv
// ----------------------------------------------------------------------------
// ebse_dp
// Datapath: block buffer, erased-run bookkeeping, flash offset and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ebse_dp #(
	parameter int BLOCK_BYTES    = ebse_pkg::BLOCK_BYTES_DEF,
	parameter int MAX_RUN_BLOCKS = ebse_pkg::MAX_RUN_BLOCKS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ebse_pkg::ADDR_W-1:0]   cfg_wdata,
	input  wire logic [ebse_pkg::BYTE_W-1:0]   in_byte,
	input  wire logic                          last_byte,
	input  wire ebse_pkg::ctl_cmd_t            cmd,
	output ebse_pkg::dp_status_t               status,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic                               kind,
	output logic      [ebse_pkg::BYTE_W-1:0]   out_byte,
	output logic      [ebse_pkg::SKIP_W-1:0]   skip_bytes,
	output logic      [ebse_pkg::ADDR_W-1:0]   address,
	output logic                               last_of_run
);
	import ebse_pkg::*;

	localparam int POS_W = $clog2(BLOCK_BYTES);
	localparam int CNT_W = $clog2(MAX_RUN_BLOCKS + 1);
	localparam logic [POS_W-1:0]  POS_END = POS_W'(BLOCK_BYTES - 1);
	localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_RUN_BLOCKS);
	localparam logic [CNT_W-1:0]  CNT_ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0]  CNT_TWO = CNT_W'(2);
	localparam logic [ADDR_W-1:0] BLK_LEN = ADDR_W'(BLOCK_BYTES);

	logic [ADDR_W-1:0] start_q;
	logic [POS_W-1:0]  pos_q;
	logic              all_ff_q;
	logic              first_ff_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] offset_q;
	logic [CNT_W-1:0]  skip_blocks_q;
	logic [POS_W-1:0]  lit_end_q;
	logic              lit_q;
	logic              last_q;
	logic [POS_W-1:0]  idx_q;
	logic              out_valid_q;
	logic              kind_q;
	logic [BYTE_W-1:0] byte_q;
	logic [SKIP_W-1:0] skip_q;
	logic [ADDR_W-1:0] addr_q;
	logic              last_q_out;

	logic              is_ff;
	logic              all_ff_n;
	logic              first_ff_n;
	logic              full;
	logic              block_end;
	logic              whole_ff;
	logic              cap;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  cnt_next;
	logic [CNT_W-1:0]  skip_blocks_n;
	logic              has_skip;
	logic              has_ff;
	logic              has_lit;
	logic [ADDR_W-1:0] skip_total;
	logic [ADDR_W-1:0] cur_addr;
	logic [POS_W-1:0]  raddr;
	logic [BYTE_W-1:0] rdata;

	// --- plan for the offered byte ---
	always_comb begin
		is_ff      = (in_byte == ERASED_BYTE);
		all_ff_n   = all_ff_q & is_ff;
		first_ff_n = (pos_q == '0) ? is_ff : first_ff_q;
		full       = (pos_q == POS_END);
		block_end  = full | last_byte;
		whole_ff   = full & all_ff_n;
		cnt_inc    = cnt_q + CNT_ONE;
		cap        = (cnt_inc >= CNT_MAX);

		has_skip      = 1'b0;
		has_ff        = 1'b0;
		has_lit       = 1'b0;
		skip_blocks_n = cnt_q;
		cnt_next      = cnt_q;
		if (block_end) begin
			if (whole_ff) begin
				// extend the erased run; settle it at the cap or image end
				skip_blocks_n = cnt_inc;
				has_skip      = cap | (last_byte & (cnt_inc >= CNT_TWO));
				has_ff        = !cap & last_byte & (cnt_inc == CNT_ONE);
				cnt_next      = (cap | last_byte) ? '0 : cnt_inc;
			end else begin
				has_skip = (cnt_q != '0) & ((cnt_q >= CNT_TWO) | first_ff_n);
				has_ff   = (cnt_q == CNT_ONE) & !first_ff_n;
				has_lit  = 1'b1;
				cnt_next = '0;
			end
		end
	end

	assign skip_total = ADDR_W'(skip_blocks_q) * BLK_LEN;
	assign cur_addr   = start_q + offset_q;
	assign raddr      = cmd.rd_ahead ? (idx_q + POS_W'(1)) : idx_q;

	ebse_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BLOCK_BYTES)
	) u_buf (
		.clk     (clk),
		.we      (cmd.accept),
		.waddr   (pos_q),
		.wdata   (in_byte),
		.re      (cmd.rd_en),
		.raddr   (raddr),
		.rdata_q (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= '0;
			pos_q       <= '0;
			all_ff_q    <= 1'b1;
			first_ff_q  <= 1'b0;
			cnt_q       <= '0;
			offset_q    <= '0;
			lit_q       <= 1'b0;
			last_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				start_q <= cfg_wdata;
			end

			if (cmd.accept) begin
				pos_q      <= block_end ? '0 : (pos_q + POS_W'(1));
				all_ff_q   <= block_end ? 1'b1 : all_ff_n;
				first_ff_q <= block_end ? 1'b0 : first_ff_n;
				cnt_q      <= last_byte ? '0 : cnt_next;
				lit_q      <= has_lit;
				last_q     <= last_byte;
			end

			if (cmd.accept || cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + POS_W'(1);
			end

			// advance past each emitted result; drop to image start at its end
			if (cmd.finish && last_q) begin
				offset_q <= '0;
			end else if (cmd.out_load) begin
				if (cmd.out_sel == SEL_SKIP) begin
					offset_q <= offset_q + skip_total;
				end else begin
					offset_q <= offset_q + ADDR_W'(1);
				end
			end

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			skip_blocks_q <= skip_blocks_n;
			lit_end_q     <= pos_q;
		end
		if (cmd.out_load) begin
			addr_q     <= cur_addr;
			last_q_out <= cmd.out_last;
			unique case (cmd.out_sel)
				SEL_SKIP: begin
					kind_q <= KIND_SKIP;
					byte_q <= '0;
					skip_q <= skip_total[SKIP_W-1:0];
				end
				SEL_FF: begin
					kind_q <= KIND_LITERAL;
					byte_q <= ERASED_BYTE;
					skip_q <= '0;
				end
				SEL_LIT: begin
					kind_q <= KIND_LITERAL;
					byte_q <= rdata;
					skip_q <= '0;
				end
				default: begin
					kind_q <= KIND_LITERAL;
					byte_q <= '0;
					skip_q <= '0;
				end
			endcase
		end
	end

	always_comb begin
		status.block_end   = block_end;
		status.has_skip    = has_skip;
		status.has_ff      = has_ff;
		status.has_lit     = has_lit;
		status.lit_pending = lit_q;
		status.out_free    = !out_valid_q | out_ready;
		status.idx_ff_end  = (idx_q == POS_END);
		status.idx_lit_end = (idx_q == lit_end_q);
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign out_byte    = byte_q;
	assign skip_bytes  = skip_q;
	assign address     = addr_q;
	assign last_of_run = last_q_out;

endmodule

`default_nettype wire

### rtl/core/erased_block_skip_encoder_top.sv
// ----------------------------------------------------------------------------
// erased_block_skip_encoder_top
// A byte that does not close a block is taken while the sequencer is idle. The
// first result of a closing byte passes the state register and the result
// register (plus the buffer read when literals lead). At most one result per
// cycle passes the result register and single read port while the sink is
// ready. Reset: arst_n clears control, counters and start_address at once;
// the block buffer is not cleared and needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module erased_block_skip_encoder_top #(
	parameter int BLOCK_BYTES    = ebse_pkg::BLOCK_BYTES_DEF,
	parameter int MAX_RUN_BLOCKS = ebse_pkg::MAX_RUN_BLOCKS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [ebse_pkg::ADDR_W-1:0] cfg_wdata,
	ebse_in_if.sink                          in_ch,
	ebse_out_if.source                       out_ch
);
	import ebse_pkg::*;

	// Command and status between the sequencer and the datapath.
	ctl_cmd_t   cmd;
	dp_status_t status;
	logic       in_ready;

	// The sequencer owns the input handshake: a transaction is taken only
	// while no earlier byte still has results to release.
	ebse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	assign in_ch.ready = in_ready;

	// The datapath buffers the block, tracks the pending erased run and
	// holds each result in its output register until the sink takes it.
	ebse_dp #(
		.BLOCK_BYTES    (BLOCK_BYTES),
		.MAX_RUN_BLOCKS (MAX_RUN_BLOCKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_byte     (in_ch.in_byte),
		.last_byte   (in_ch.last_byte),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (out_ch.ready),
		.out_valid   (out_ch.valid),
		.kind        (out_ch.kind),
		.out_byte    (out_ch.out_byte),
		.skip_bytes  (out_ch.skip_bytes),
		.address     (out_ch.address),
		.last_of_run (out_ch.last_of_run)
	);

endmodule

`default_nettype wire
